// ===== rtl/core/sck_pkg.sv =====
// Package for the SHA-1 counter keystream XOR block.
// Holds shared types, constants and the SHA-1 round helpers; no dependencies.
`default_nettype none
package sck_pkg;
    localparam int KEY_WORDS = 7;
    localparam int ADDR_W = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] PAD_WORD = 32'h80000000;
    localparam logic [31:0] MSG_BITS = 32'h00000200;

    typedef struct packed {
        logic [59:0] counter;
        logic [3:0]  pos;
        logic [7:0]  data;
        logic        refill;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_OUT
    } back_state_t;

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        if (t < 7'd20) round_f = (b & c) | (~b & d);
        else if (t < 7'd40) round_f = b ^ c ^ d;
        else if (t < 7'd60) round_f = (b & c) | (b & d) | (c & d);
        else round_f = b ^ c ^ d;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        if (t < 7'd20) round_k = 32'h5A827999;
        else if (t < 7'd40) round_k = 32'h6ED9EBA1;
        else if (t < 7'd60) round_k = 32'h8F1BBCDC;
        else round_k = 32'hCA62C1D6;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/sck_front.sv =====
// Front part: accepts items, classifies refill against the cached counter.
// Depends on sck_pkg.
`default_nettype none
module sck_front
    import sck_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] byte_offset,
    input  wire logic [7:0]  data_in,
    input  wire logic        key_write,
    output logic             q_valid,
    output job_t             q_job,
    input  wire logic        q_pop
);
    job_t        slot_reg [QUEUE_DEPTH];
    logic [1:0]  count_reg, count_next;
    logic        rd_reg, wr_reg;
    logic [59:0] cnt_reg;
    logic        cv_reg;
    logic        push;
    job_t        job;

    assign in_stall = (count_reg == 2'(QUEUE_DEPTH));
    assign push = in_valid && !in_stall;
    assign q_valid = (count_reg != 2'd0);
    assign q_job = slot_reg[rd_reg];

    always_comb
    begin
        job.counter = byte_offset[63:4];
        job.pos = byte_offset[3:0];
        job.data = data_in;
        job.refill = !cv_reg || (cnt_reg != byte_offset[63:4]);
        count_next = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
            cnt_reg <= '0;
            cv_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (q_pop) rd_reg <= ~rd_reg;
            if (push)
            begin
                wr_reg <= ~wr_reg;
                cnt_reg <= job.counter;
                cv_reg <= 1'b1;
            end
            else if (key_write)
                cv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_reg] <= job;
    end
endmodule
`default_nettype wire

// ===== rtl/core/sck_back.sv =====
// Back part: runs two SHA-1 compressions per refill, one round a cycle.
// Depends on sck_pkg.
`default_nettype none
module sck_back
    import sck_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [447:0]  key_bits,
    input  wire logic          q_valid,
    input  wire job_t          q_job,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         data_out
);
    back_state_t state_reg, state_next;
    logic [6:0]   t_reg;
    logic         blk_reg;
    logic [31:0]  w_reg [16];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  h_reg [5];
    logic [127:0] ks_reg;
    logic [7:0]   out_reg;
    logic [31:0]  w_cur, w_new, tmp;
    logic         start, done_round;
    logic [127:0] ks_sel;
    logic [127:0] ks_use;
    logic [3:0]   pos_reg;
    logic [7:0]   data_reg;

    assign start = (state_reg == ST_IDLE) && q_valid;
    assign done_round = (state_reg == ST_HASH) && (t_reg == 7'd79);

    always_comb
    begin
        w_new = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_new[30:0], w_new[31]};
        w_cur = (t_reg < 7'd16) ? w_reg[0] : w_new;
        tmp = {a_reg[26:0], a_reg[31:27]} + round_f(t_reg, b_reg, c_reg, d_reg)
              + e_reg + round_k(t_reg) + w_cur;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid) state_next = q_job.refill ? ST_HASH : ST_OUT;
            ST_HASH: if (done_round && blk_reg) state_next = ST_OUT;
            ST_OUT:  if (!out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid = (state_reg == ST_OUT);
        q_pop = out_valid && !out_stall;
        data_out = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign ks_sel = {h_reg[0] + tmp, h_reg[1] + a_reg,
                     h_reg[2] + {b_reg[1:0], b_reg[31:2]}, h_reg[3] + c_reg};

    always_ff @(posedge clk)
    begin
        if (start && q_job.refill)
        begin
            t_reg <= '0;
            blk_reg <= 1'b0;
            for (int i = 0; i < 14; i++)
                w_reg[i] <= key_bits[447 - 32*i -: 32];
            w_reg[14] <= {4'd0, q_job.counter[59:32]};
            w_reg[15] <= q_job.counter[31:0];
            {a_reg, b_reg, c_reg, d_reg, e_reg} <= {H0, H1, H2, H3, H4};
            h_reg[0] <= H0; h_reg[1] <= H1; h_reg[2] <= H2;
            h_reg[3] <= H3; h_reg[4] <= H4;
        end
        else if (state_reg == ST_HASH)
        begin
            if (done_round)
            begin
                h_reg[0] <= h_reg[0] + tmp;
                h_reg[1] <= h_reg[1] + a_reg;
                h_reg[2] <= h_reg[2] + {b_reg[1:0], b_reg[31:2]};
                h_reg[3] <= h_reg[3] + c_reg;
                h_reg[4] <= h_reg[4] + d_reg;
                a_reg <= h_reg[0] + tmp;
                b_reg <= h_reg[1] + a_reg;
                c_reg <= h_reg[2] + {b_reg[1:0], b_reg[31:2]};
                d_reg <= h_reg[3] + c_reg;
                e_reg <= h_reg[4] + d_reg;
                t_reg <= '0;
                blk_reg <= 1'b1;
                w_reg[0] <= PAD_WORD;
                for (int i = 1; i < 15; i++) w_reg[i] <= '0;
                w_reg[15] <= MSG_BITS;
                if (blk_reg)
                    ks_reg <= {h_reg[0] + tmp, h_reg[1] + a_reg,
                               h_reg[2] + {b_reg[1:0], b_reg[31:2]}, h_reg[3] + c_reg};
            end
            else
            begin
                t_reg <= t_reg + 7'd1;
                for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                w_reg[15] <= w_cur;
                e_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= {b_reg[1:0], b_reg[31:2]};
                b_reg <= a_reg;
                a_reg <= tmp;
            end
        end
    end

    assign ks_use = ks_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pos_reg <= q_job.pos;
            data_reg <= q_job.data;
        end
        if (start && !q_job.refill)
            out_reg <= q_job.data ^ ks_use[127 - 8*q_job.pos -: 8];
        else if (done_round && blk_reg)
            out_reg <= data_reg ^ ks_sel[127 - 8*pos_reg -: 8];
    end
endmodule
`default_nettype wire

// ===== rtl/core/sha1_counter_keystream_xor.sv =====
// Top level of the SHA-1 counter keystream XOR block.
// Uses sck_pkg, sck_front and sck_back.
//
// Input channel: in_valid/in_stall with byte_offset and data_in. Output
// channel: out_valid/out_stall with data_out, one result per item, in order.
// Key words are written over the APB port at byte address 8*i.
// The front part checks each item's counter against the last accepted one
// and queues it (two entries). The back part runs one SHA-1 round per cycle.
// An item with the cached counter goes from idle straight to output; a new
// counter first costs 160 rounds (two compressions) in the round loop.
// Reset clears the cache and control state. A stalled result holds; the
// queue keeps accepting until full, then in_stall rises.
`default_nettype none
module sha1_counter_keystream_xor
    import sck_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [63:0]       pwdata,
    output logic [63:0]            prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [63:0]       byte_offset,
    input  wire logic [7:0]        data_in,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             data_out
);
    logic [63:0]  key_reg [KEY_WORDS];
    logic [447:0] key_bits;
    logic         wr, q_valid, q_pop;
    job_t         q_job;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite && (paddr[ADDR_W-1:3] < 3'(KEY_WORDS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < KEY_WORDS; i++) key_reg[i] <= '0;
        else if (wr)
            key_reg[paddr[ADDR_W-1:3]] <= pwdata;
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[ADDR_W-1:3] < 3'(KEY_WORDS)) prdata = key_reg[paddr[ADDR_W-1:3]];
        key_bits = '0;
        for (int i = 0; i < KEY_WORDS; i++) key_bits[447 - 64*i -: 64] = key_reg[i];
    end

    sck_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .byte_offset(byte_offset), .data_in(data_in), .key_write(wr),
        .q_valid(q_valid), .q_job(q_job), .q_pop(q_pop)
    );

    sck_back u_back (
        .clk(clk), .rst_n(rst_n), .key_bits(key_bits), .q_valid(q_valid),
        .q_job(q_job), .q_pop(q_pop), .out_valid(out_valid),
        .out_stall(out_stall), .data_out(data_out)
    );

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop of empty queue");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_out))
        else $error("stalled result changed");
endmodule
`default_nettype wire

// ===== tb/sv/sha1_counter_keystream_xor_tb.sv =====
// Testbench for sha1_counter_keystream_xor: drives byte items with random offsets and keys,
// predicts each keystream byte with its own SHA-1 and checks results in order.
// Depends on sck_pkg and the sha1_counter_keystream_xor RTL.
`default_nettype none
module sha1_counter_keystream_xor_tb
    import sck_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [63:0]       pwdata = '0;
    logic [63:0]       prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [63:0]       byte_offset = '0;
    logic [7:0]        data_in = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        data_out;

    logic [63:0] key_regs [KEY_WORDS];
    logic [59:0] ks_counter;
    logic        ks_valid;
    logic [7:0]  ks_bytes [16];
    logic [7:0]  expected_bytes [$];
    int          mismatch_count = 0;
    bit          idle_on = 1'b1;
    int          hold_cycles = 0;

    sha1_counter_keystream_xor u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic sha1_block(inout logic [31:0] h [5], input logic [31:0] msg [16]);
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        w = msg;
        a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r >= 16)
                w[r % 16] = rol(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16]
                                ^ w[r % 16], 1);
            if (r < 20)
            begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[r % 16];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
    endtask

    task automatic predict_byte(input logic [63:0] off, input logic [7:0] din);
        logic [31:0] h [5];
        logic [31:0] msg [16];
        logic [59:0] ctr;
        ctr = off[63:4];
        if (!ks_valid || ks_counter != ctr)
        begin
            h = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                msg[2 * i] = key_regs[i][63:32];
                msg[2 * i + 1] = key_regs[i][31:0];
            end
            msg[14] = {4'b0, ctr[59:32]};
            msg[15] = ctr[31:0];
            sha1_block(h, msg);
            foreach (msg[i]) msg[i] = 32'h0;
            msg[0] = 32'h80000000;
            msg[15] = 32'h00000200;
            sha1_block(h, msg);
            for (int i = 0; i < 16; i++)
                ks_bytes[i] = 8'(h[i / 4] >> (24 - 8 * (i % 4)));
            ks_counter = ctr;
            ks_valid = 1'b1;
        end
        expected_bytes.push_back(din ^ ks_bytes[off[3:0]]);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_key(input int idx, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * idx); pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx < KEY_WORDS)
        begin
            key_regs[idx] = value;
            ks_valid = 1'b0;
        end
    endtask

    task automatic send_byte(input logic [63:0] off, input logic [7:0] din);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_offset <= off;
        data_in <= din;
        do @(posedge clk); while (in_stall);
        predict_byte(off, din);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed();
        send_byte(64'h0, 8'h00);
        send_byte(64'h0, 8'hFF);
        send_byte(64'hF, 8'hA5);
        send_byte(64'h10, 8'h5A);
        send_byte(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        send_byte(64'hFFFF_FFFF_FFFF_FFF0, 8'h01);
        send_byte(64'h0000_0001_0000_0000, 8'h80);
        send_byte(64'h8000_0000_0000_0007, 8'h7F);
        send_byte(64'h0, 8'h3C);
        wait_drained();
        for (int i = 0; i < KEY_WORDS; i++)
            write_key(i, 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(64'h0, 8'h00);
        send_byte(64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
        wait_drained();
        write_key(3, 64'h0123_4567_89AB_CDEF);
        send_byte(64'hFFFF_FFFF_FFFF_FFFF, 8'h11);
        wait_drained();
        write_key(7, 64'hDEAD_BEEF_0000_0000);
        send_byte(64'hFFFF_FFFF_FFFF_FFFE, 8'h22);
        wait_drained();
    endtask

    task automatic test_random_keys_streams(input int n);
        logic [63:0] base;
        int sent;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                wait_drained();
                for (int i = 0; i < KEY_WORDS; i++)
                    write_key(i, ($urandom_range(0, 5) == 0) ? 64'h0 : rand64());
            end
            base = ($urandom_range(0, 3) == 0) ? rand64() : {32'h0, $urandom_range(0, 4096)};
            for (int j = 0; j < 16 && sent < n; j++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_byte(rand64(), 8'($urandom_range(0, 255)));
                else
                    send_byte(base + j, 8'($urandom_range(0, 255)));
                sent++;
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_cycles = 600;
        for (int j = 0; j < 24; j++)
            send_byte({32'h0, $urandom()} + (j / 3) * 16, 8'($urandom_range(0, 255)));
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
            out_stall <= ~out_stall;
        else if (!idle_on)
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected data_out %h", data_out);
            end
            else
            begin
                logic [7:0] exp_b;
                exp_b = expected_bytes.pop_front();
                if (data_out !== exp_b)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("data_out mismatch: expected %h actual %h", exp_b, data_out);
                end
            end
        end
    end

    initial
    begin
        foreach (key_regs[i]) key_regs[i] = 64'h0;
        ks_valid = 1'b0;
        ks_counter = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_keys_streams(1500);
        idle_on = 1'b0;
        test_random_keys_streams(300);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
